/* rtl/core/rmst_pkg.sv */
// Shared types and constants for the range minimum segment tree.
// Used by the channel interfaces, the node memory, the min unit and the top level.
// No dependencies.
`timescale 1ns / 1ps

package rmst_pkg;

    // Field widths of the transaction payloads.
    localparam int VALUE_W = 63;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // Signed node value as stored in the tree.
    typedef logic signed [VALUE_W-1:0] value_t;

    // Largest value, held by every node after reset and returned for empty ranges.
    localparam value_t VALUE_MAX = 63'sh3FFF_FFFF_FFFF_FFFF;

    // Reset value of the leaves-in-use register.
    localparam logic [COUNT_W-1:0] LEAVES_RESET = 11'd1024;

    // Request modes.
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

endpackage

/* rtl/core/rmst_if.sv */
// Valid/ready channel interfaces for requests and query responses.
// Depends on rmst_pkg for the payload widths.
`timescale 1ns / 1ps

interface rmst_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [rmst_pkg::INDEX_W-1:0]  leaf_index;
    rmst_pkg::value_t              new_value;
    logic [rmst_pkg::INDEX_W-1:0]  range_low;
    logic [rmst_pkg::INDEX_W-1:0]  range_high;

    modport source (
        output valid, mode, leaf_index, new_value, range_low, range_high,
        input  ready
    );
    modport sink (
        input  valid, mode, leaf_index, new_value, range_low, range_high,
        output ready
    );
endinterface

interface rmst_rsp_if;
    logic              valid;
    logic              ready;
    rmst_pkg::value_t  minimum;
    logic              range_valid;

    modport source (
        output valid, minimum, range_valid,
        input  ready
    );
    modport sink (
        input  valid, minimum, range_valid,
        output ready
    );
endinterface

/* rtl/core/range_min_segment_tree.sv */
// Range minimum segment tree with point min-update, top level and sequencer.
// Depends on rmst_pkg, rmst_if, rmst_node_mem and rmst_min_unit.
//
//  channel | direction | payload                                    | handshake
//  --------+-----------+--------------------------------------------+-------------
//  req     | in        | mode, leaf_index, new_value, range_low/high | valid/ready
//  rsp     | out       | minimum, range_valid                        | valid/ready
//  cfg     | in        | cfg_data (leaves in use)                    | cfg_write
//
// An update does one node read and one node write per tree level through the min unit
// and the node memory, which has one write port and one read port. A query reads at
// most two nodes per level. After reset a clearing pass writes the largest value to
// every node before ready rises. A finished query result waits in the output register;
// the next transaction may start meanwhile, and only a second query stalls at its end
// until the result is taken.
`timescale 1ns / 1ps

module range_min_segment_tree #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rmst_req_if.sink                      req,
    rmst_rsp_if.source                    rsp,
    input  logic                          cfg_write,
    input  logic [rmst_pkg::COUNT_W-1:0]  cfg_data
);

    localparam int DEPTH = 2 * LEAF_COUNT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROOT_NODE = AW'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_WALK,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_OUT
    } state_t;

    state_t                       state_reg, state_next;
    logic [AW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]                node_reg, node_next;
    logic [AW:0]                  l_reg, l_next;
    logic [AW:0]                  r_reg, r_next;
    rmst_pkg::value_t             acc_reg, acc_next;
    logic                         pend_reg, pend_next;
    logic                         qflag_reg, qflag_next;
    logic                         out_valid_reg, out_valid_next;
    rmst_pkg::value_t             out_min_reg, out_min_next;
    logic                         out_flag_reg, out_flag_next;
    logic [rmst_pkg::COUNT_W-1:0] leaves_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_wr_addr;
    rmst_pkg::value_t mem_wr_data;
    logic             mem_re;
    logic [AW-1:0]    mem_rd_addr;
    rmst_pkg::value_t mem_rd_data;
    rmst_pkg::value_t min_y;

    logic [AW-1:0]    leaf_node;
    logic [AW-1:0]    parent;
    logic [AW:0]      r_dec;
    logic             leaf_ok;
    logic             query_ok;

    // True when a leaf index lies below both LEAF_COUNT and the leaves in use (zero admits index 0).
    function automatic logic in_range(
        input logic [rmst_pkg::INDEX_W-1:0] idx,
        input logic [rmst_pkg::COUNT_W-1:0] count
    );
        logic below_param;
        logic below_count;
        below_param = 32'(idx) < 32'(LEAF_COUNT);
        below_count = (32'(idx) < 32'(count)) || ((count == '0) && (idx == '0));
        return below_param && below_count;
    endfunction

    rmst_node_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_re),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Every merge compares the fresh node read against the running value.
    rmst_min_unit u_min (
        .a (mem_rd_data),
        .b (acc_reg),
        .y (min_y)
    );

    // Request decode.
    assign leaf_node = AW'(32'(req.leaf_index) + LEAF_COUNT);
    assign leaf_ok   = in_range(req.leaf_index, leaves_reg);
    assign query_ok  = (req.range_low <= req.range_high) &&
                       in_range(req.range_high, leaves_reg);
    assign parent    = node_reg >> 1;
    assign r_dec     = r_reg - (AW + 1)'(1);

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.minimum     = out_min_reg;
    assign rsp.range_valid = out_flag_reg;

    // Sequencer next-state and memory control.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        node_next      = node_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        pend_next      = 1'b0;
        qflag_next     = qflag_reg;
        out_valid_next = out_valid_reg;
        out_min_next   = out_min_reg;
        out_flag_next  = out_flag_reg;
        mem_we         = 1'b0;
        mem_wr_addr    = node_reg;
        mem_wr_data    = min_y;
        mem_re         = 1'b0;
        mem_rd_addr    = node_reg;

        // The response register empties when the transaction completes.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = rmst_pkg::VALUE_MAX;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.mode == rmst_pkg::MODE_UPDATE)
                    begin
                        // Out-of-range updates are dropped here.
                        if (leaf_ok)
                        begin
                            node_next   = leaf_node;
                            mem_re      = 1'b1;
                            mem_rd_addr = leaf_node;
                            acc_next    = req.new_value;
                            state_next  = ST_UPD_LEAF;
                        end
                    end
                    else
                    begin
                        acc_next = rmst_pkg::VALUE_MAX;
                        if (query_ok)
                        begin
                            l_next     = (AW + 1)'(32'(req.range_low) + LEAF_COUNT);
                            r_next     = (AW + 1)'(32'(req.range_high) + LEAF_COUNT + 1);
                            qflag_next = 1'b1;
                            state_next = ST_Q_LEFT;
                        end
                        else
                        begin
                            qflag_next = 1'b0;
                            state_next = ST_Q_OUT;
                        end
                    end
                end
            end

            ST_UPD_LEAF:
            begin
                // Lower the leaf and fetch its sibling.
                mem_we      = 1'b1;
                mem_wr_addr = node_reg;
                acc_next    = min_y;
                mem_re      = 1'b1;
                mem_rd_addr = {node_reg[AW-1:1], ~node_reg[0]};
                state_next  = ST_UPD_WALK;
            end

            ST_UPD_WALK:
            begin
                // Write the parent and fetch the parent's sibling in the same cycle.
                mem_we      = 1'b1;
                mem_wr_addr = parent;
                acc_next    = min_y;
                node_next   = parent;
                if (parent == ROOT_NODE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_rd_addr = {parent[AW-1:1], ~parent[0]};
                end
            end

            ST_Q_LEFT:
            begin
                if (pend_reg)
                begin
                    acc_next = min_y;
                end
                if (l_reg >= r_reg)
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    // An odd left bound is a right child: take it and step past it.
                    if (l_reg[0])
                    begin
                        mem_re      = 1'b1;
                        mem_rd_addr = l_reg[AW-1:0];
                        l_next      = l_reg + (AW + 1)'(1);
                        pend_next   = 1'b1;
                    end
                    state_next = ST_Q_RIGHT;
                end
            end

            ST_Q_RIGHT:
            begin
                if (pend_reg)
                begin
                    acc_next = min_y;
                end
                // An odd right bound excludes a left child just below it: take it.
                if (r_reg[0])
                begin
                    mem_re      = 1'b1;
                    mem_rd_addr = r_dec[AW-1:0];
                    pend_next   = 1'b1;
                    r_next      = r_dec >> 1;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                l_next     = l_reg >> 1;
                state_next = ST_Q_LEFT;
            end

            ST_Q_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_min_next   = acc_reg;
                    out_flag_next  = qflag_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            node_reg      <= '0;
            l_reg         <= '0;
            r_reg         <= '0;
            acc_reg       <= rmst_pkg::VALUE_MAX;
            pend_reg      <= 1'b0;
            qflag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_min_reg   <= rmst_pkg::VALUE_MAX;
            out_flag_reg  <= 1'b0;
            leaves_reg    <= rmst_pkg::LEAVES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            node_reg      <= node_next;
            l_reg         <= l_next;
            r_reg         <= r_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            qflag_reg     <= qflag_next;
            out_valid_reg <= out_valid_next;
            out_min_reg   <= out_min_next;
            out_flag_reg  <= out_flag_next;
            if (cfg_write)
            begin
                leaves_reg <= cfg_data;
            end
        end
    end

    // A node is never read and written at the same address in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_wr_addr != mem_rd_addr))
        else $error("node memory read and write collide");

    // Pending read data only arrives while a query walks the tree.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_Q_LEFT || state_reg == ST_Q_RIGHT))
        else $error("read data pending outside a query walk");

    // The query bounds never cross while walking up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_LEFT || state_reg == ST_Q_RIGHT) |-> (l_reg <= r_reg))
        else $error("query bounds crossed");

    // An invalid range always reports the largest value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.range_valid) |-> (rsp.minimum == rmst_pkg::VALUE_MAX))
        else $error("invalid range with a value other than the largest");

endmodule

/* rtl/core/rmst_node_mem.sv */
// Tree node storage: one write port and one read port with registered read data.
// Depends on rmst_pkg for the node value type.
`timescale 1ns / 1ps

module rmst_node_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  rmst_pkg::value_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output rmst_pkg::value_t rd_data
);

    rmst_pkg::value_t mem [DEPTH];
    rmst_pkg::value_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered and available in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rmst_min_unit.sv */
// Shared signed minimum unit used for every merge in updates and queries.
// Depends on rmst_pkg for the node value type.
`timescale 1ns / 1ps

module rmst_min_unit (
    input  rmst_pkg::value_t a,
    input  rmst_pkg::value_t b,
    output rmst_pkg::value_t y
);

    // Signed compare and select.
    assign y = (a < b) ? a : b;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the range minimum segment tree (range_min_segment_tree).
// Depends on rmst_pkg and the rmst_req_if / rmst_rsp_if channel interfaces of the RTL.
// Drives directed and random update/query transactions and checks every query result.
`timescale 1ns / 1ps

module testbench;

    localparam int LEAF_COUNT    = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 20000;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 53;
    localparam rmst_pkg::value_t VALUE_MIN = {1'b1, {(rmst_pkg::VALUE_W-1){1'b0}}};

    // One request transaction as the sender sees it.
    typedef struct packed {
        logic                         mode;
        logic [rmst_pkg::INDEX_W-1:0] leaf_index;
        rmst_pkg::value_t             new_value;
        logic [rmst_pkg::INDEX_W-1:0] range_low;
        logic [rmst_pkg::INDEX_W-1:0] range_high;
    } request_t;

    // One query result the block owes us.
    typedef struct packed {
        rmst_pkg::value_t minimum;
        logic             range_valid;
    } min_answer_t;

    // Mirror of the tree contents with the queue of answers still owed.
    class RangeMinScoreboard;
        rmst_pkg::value_t             leaf_val[LEAF_COUNT];
        logic [rmst_pkg::COUNT_W-1:0] leaves_reg;
        min_answer_t                  owed_answers[$];
        int                           fail_count;
        int                           updates_applied;
        int                           updates_ignored;
        int                           queries_in_range;
        int                           queries_empty;

        function new();
            foreach (leaf_val[i])
                leaf_val[i] = rmst_pkg::VALUE_MAX;
            leaves_reg = rmst_pkg::LEAVES_RESET;
            fail_count = 0;
            updates_applied = 0;
            updates_ignored = 0;
            queries_in_range = 0;
            queries_empty = 0;
        endfunction

        function void set_leaves(logic [rmst_pkg::COUNT_W-1:0] v);
            leaves_reg = v;
        endfunction

        // Zero counts as one leaf and anything past the tree size as the full tree.
        function int active_leaves();
            if (leaves_reg == 0)
                return 1;
            if (leaves_reg > LEAF_COUNT)
                return LEAF_COUNT;
            return int'(leaves_reg);
        endfunction

        function int pending();
            return owed_answers.size();
        endfunction

        // Apply an accepted request to the mirror and queue the answer it owes.
        function void note_request(request_t r);
            int          lim;
            int          i;
            min_answer_t ans;
            lim = active_leaves();
            if (r.mode == rmst_pkg::MODE_UPDATE) begin
                if (int'(r.leaf_index) >= lim) begin
                    updates_ignored++;
                end
                else begin
                    if (r.new_value < leaf_val[r.leaf_index])
                        leaf_val[r.leaf_index] = r.new_value;
                    updates_applied++;
                end
            end
            else begin
                ans.minimum = rmst_pkg::VALUE_MAX;
                ans.range_valid = 1'b0;
                if (r.range_low <= r.range_high && int'(r.range_high) < lim) begin
                    ans.range_valid = 1'b1;
                    for (i = int'(r.range_low); i <= int'(r.range_high); i++)
                        if (leaf_val[i] < ans.minimum)
                            ans.minimum = leaf_val[i];
                    queries_in_range++;
                end
                else begin
                    queries_empty++;
                end
                owed_answers = {owed_answers, ans};
            end
        endfunction

        // Compare one accepted result with the oldest owed answer.
        function void check_result(rmst_pkg::value_t minimum, logic range_valid);
            min_answer_t want;
            if (owed_answers.size() == 0) begin
                $error("result with no query outstanding: minimum %0d, range_valid %0b",
                       minimum, range_valid);
                fail_count++;
                return;
            end
            want = owed_answers.pop_front();
            if (minimum !== want.minimum) begin
                $error("minimum mismatch: expected %0d, actual %0d", want.minimum, minimum);
                fail_count++;
            end
            if (range_valid !== want.range_valid) begin
                $error("range_valid mismatch: expected %0b, actual %0b",
                       want.range_valid, range_valid);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [rmst_pkg::COUNT_W-1:0] cfg_data;

    rmst_req_if req_ch ();
    rmst_rsp_if rsp_ch ();

    RangeMinScoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  req_up;
    int  stall_cycles;
    int  settings_used;

    range_min_segment_tree #(
        .LEAF_COUNT (LEAF_COUNT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Response side: check each accepted result, then pick ready for the next cycle.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((rsp_ch.valid & rsp_ch.ready) === 1'b1)
                sb.check_result(rsp_ch.minimum, rsp_ch.range_valid);
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: give up when no transaction moves on either channel for too long.
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid & req_ch.ready) === 1'b1 ||
                (rsp_ch.valid & rsp_ch.ready) === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic request_t make_update(int idx, rmst_pkg::value_t v);
        request_t r;
        r = '0;
        r.mode = rmst_pkg::MODE_UPDATE;
        r.leaf_index = idx[rmst_pkg::INDEX_W-1:0];
        r.new_value = v;
        return r;
    endfunction

    function automatic request_t make_query(int lo, int hi);
        request_t r;
        r = '0;
        r.mode = rmst_pkg::MODE_QUERY;
        r.range_low = lo[rmst_pkg::INDEX_W-1:0];
        r.range_high = hi[rmst_pkg::INDEX_W-1:0];
        return r;
    endfunction

    // Values mix the extremes, a narrow band near zero and full-width noise.
    function automatic rmst_pkg::value_t pick_value();
        int kind;
        kind = $urandom_range(9);
        case (kind)
            0: return rmst_pkg::VALUE_MAX;
            1: return VALUE_MIN;
            2: return ($urandom_range(1) != 0) ? rmst_pkg::value_t'(-1) : rmst_pkg::value_t'(0);
            3, 4, 5: return rmst_pkg::value_t'({$urandom, $urandom});
            default: return rmst_pkg::value_t'(int'($urandom_range(200000)) - 100000);
        endcase
    endfunction

    // Mostly well-formed requests inside the leaves in use, with some strays.
    function automatic request_t random_request(int lim);
        request_t r;
        int       lo;
        int       hi;
        int       pick;
        r.leaf_index = rmst_pkg::INDEX_W'($urandom);
        r.new_value = rmst_pkg::value_t'({$urandom, $urandom});
        r.range_low = rmst_pkg::INDEX_W'($urandom);
        r.range_high = rmst_pkg::INDEX_W'($urandom);
        if ($urandom_range(99) < 50) begin
            r.mode = rmst_pkg::MODE_UPDATE;
            if ($urandom_range(99) < 85)
                r.leaf_index = rmst_pkg::INDEX_W'($urandom_range(lim - 1));
            r.new_value = pick_value();
        end
        else begin
            r.mode = rmst_pkg::MODE_QUERY;
            pick = $urandom_range(99);
            if (pick < 70) begin
                lo = $urandom_range(lim - 1);
                hi = ($urandom_range(3) == 0) ? lo : int'($urandom_range(lim - 1, lo));
                r.range_low = rmst_pkg::INDEX_W'(lo);
                r.range_high = rmst_pkg::INDEX_W'(hi);
            end
            else if (pick < 80 && lim > 1) begin
                hi = $urandom_range(lim - 2);
                r.range_low = rmst_pkg::INDEX_W'($urandom_range(lim - 1, hi + 1));
                r.range_high = rmst_pkg::INDEX_W'(hi);
            end
        end
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input request_t r);
        while ($urandom_range(99) < tx_idle_pct) begin
            if (req_up) begin
                req_ch.valid <= 1'b0;
                req_up = 1'b0;
            end
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_up = 1'b1;
        req_ch.mode <= r.mode;
        req_ch.leaf_index <= r.leaf_index;
        req_ch.new_value <= r.new_value;
        req_ch.range_low <= r.range_low;
        req_ch.range_high <= r.range_high;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(r);
    endtask

    // Stop sending, wait for every owed answer, then let a trailing update finish.
    task automatic settle();
        if (req_up) begin
            req_ch.valid <= 1'b0;
            req_up = 1'b0;
        end
        do
            @(posedge clk);
        while (sb.pending() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_leaves(input logic [rmst_pkg::COUNT_W-1:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        sb.set_leaves(v);
        settings_used++;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_idle_pattern(input int pattern);
        case (pattern)
            0: begin tx_idle_pct = 8;  rx_idle_pct = 48; end
            1: begin tx_idle_pct = 48; rx_idle_pct = 8;  end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
    endtask

    // Main sequence: reset, directed checks, then random phases over several leaf counts.
    initial
    begin
        int unsigned phase_leaves[PHASE_COUNT];
        int          phase_pattern[PHASE_COUNT];
        request_t    directed[$];
        int          p;
        int          k;

        phase_leaves = '{700, 1, 1024, 2, 1500, 0, 37, 1024, 2047};
        phase_pattern = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
        sb = new();
        settings_used = 0;
        req_up = 1'b0;
        set_idle_pattern(0);

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.mode = rmst_pkg::MODE_UPDATE;
        req_ch.leaf_index = '0;
        req_ch.new_value = '0;
        req_ch.range_low = '0;
        req_ch.range_high = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Untouched tree, empty ranges, extreme values and updates that cannot lower a leaf.
        directed = {directed, make_query(0, 1023)};
        directed = {directed, make_query(5, 4)};
        directed = {directed, make_update(0, rmst_pkg::value_t'(-1))};
        directed = {directed, make_update(1023, VALUE_MIN)};
        directed = {directed, make_update(512, rmst_pkg::value_t'(0))};
        directed = {directed, make_update(511, rmst_pkg::value_t'(100))};
        directed = {directed, make_update(511, rmst_pkg::value_t'(200))};
        directed = {directed, make_update(0, rmst_pkg::VALUE_MAX)};
        directed = {directed, make_query(0, 0)};
        directed = {directed, make_query(1023, 1023)};
        directed = {directed, make_query(0, 1023)};
        directed = {directed, make_query(1, 1022)};
        directed = {directed, make_query(511, 511)};
        directed = {directed, make_query(513, 1022)};
        directed = {directed, make_query(1023, 0)};
        foreach (directed[i])
            send_request(directed[i]);
        settle();

        // A leaf count of zero behaves as one: strays are ignored or reported outside.
        write_leaves(11'd0);
        send_request(make_update(1, rmst_pkg::value_t'(-5)));
        send_request(make_update(0, rmst_pkg::value_t'(-7)));
        send_request(make_query(0, 0));
        send_request(make_query(0, 1));
        settle();

        // An oversize count acts as the full tree, and the contents survive the change.
        write_leaves(11'd2047);
        send_request(make_query(0, 1023));
        send_request(make_query(1, 1022));
        settle();

        // Random phases; each one pauses halfway until all answers are back.
        for (p = 0; p < PHASE_COUNT; p++) begin
            set_idle_pattern(phase_pattern[p]);
            write_leaves(phase_leaves[p][rmst_pkg::COUNT_W-1:0]);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_request(random_request(sb.active_leaves()));
                if (k == PHASE_ITEMS / 2)
                    settle();
            end
            settle();
        end

        $display("Covered %0d applied and %0d ignored updates, %0d in-range and %0d empty queries,",
                 sb.updates_applied, sb.updates_ignored, sb.queries_in_range, sb.queries_empty);
        $display("across %0d leaf-count writes and three handshake idle patterns.",
                 settings_used);
        if (sb.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rmst_pkg.sv
rtl/core/rmst_if.sv
rtl/core/rmst_node_mem.sv
rtl/core/rmst_min_unit.sv
rtl/core/range_min_segment_tree.sv
test/testbench.sv
